// ----- sv/hkvt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants of the hashed key-value table.
package hkvt_pkg;

    localparam int KEY_W     = 64;
    localparam int VALUE_W   = 32;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 3;
    localparam int ENTRIES_W = 9;

    localparam int DEF_BUCKETS    = 64;
    localparam int DEF_WAYS       = 4;
    localparam int DEF_VALUE_BITS = 32;

    localparam logic [KEY_W-1:0] HASH_MULT = 64'd11400714819323198549;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_INVALID   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;

    // Outcome of one request on its bucket row.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value_out;
        logic                wr;
        logic                inc;
        logic                dec;
    } match_res_t;

endpackage

// ----- sv/hkvt_hash.sv -----
`timescale 1ns / 1ps
// Bucket index unit: key times the Fibonacci constant, modulo the bucket count.
module hkvt_hash
    import hkvt_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [KEY_W-1:0]           key_in,
    output logic                       done,
    output logic [$clog2(BUCKETS)-1:0] bucket
);

    localparam int BB      = $clog2(BUCKETS);
    localparam bit IS_POW2 = ((1 << BB) == BUCKETS);

    generate
        if (IS_POW2) begin : g_pow2
            // Only the low bits of the product matter, and they depend only on
            // the low bits of both factors.
            logic [2*BB-1:0] prod;

            assign prod   = key_in[BB-1:0] * HASH_MULT[BB-1:0];
            assign bucket = prod[BB-1:0];
            assign done   = start;
        end else begin : g_iter
            localparam int MUL_STEPS = 4;
            localparam int MOD_STEPS = KEY_W / 4;
            localparam int LAST_STEP = MUL_STEPS + MOD_STEPS - 1;
            localparam int STEP_W    = $clog2(LAST_STEP + 1);
            localparam int TW        = BB + 4;

            logic [KEY_W-1:0]  key_reg;
            logic [KEY_W-1:0]  acc_reg;
            logic [KEY_W-1:0]  acc_next;
            logic [BB-1:0]     r_reg;
            logic [BB-1:0]     r_next;
            logic [STEP_W-1:0] step_reg;
            logic              busy_reg;
            logic [15:0]       chunk;
            logic [79:0]       part;
            logic [5:0]        shamt;
            logic [TW-1:0]     t;
            logic [TW-1:0]     rem;

            // Multiply phase: one 16-bit slice of the constant per step.
            // Reduce phase: one nibble of the product per step, most
            // significant first, by compare and subtract of m * BUCKETS.
            always_comb
            begin
                shamt    = {step_reg[1:0], 4'b0000};
                chunk    = 16'(HASH_MULT >> shamt);
                part     = key_reg * chunk;
                t        = {r_reg, acc_reg[KEY_W-1 -: 4]};
                rem      = t;
                acc_next = acc_reg;
                r_next   = r_reg;
                for (int m = 1; m < 16; m++)
                begin
                    if (t >= TW'(m * BUCKETS))
                    begin
                        rem = t - TW'(m * BUCKETS);
                    end
                end
                if (step_reg < STEP_W'(MUL_STEPS))
                begin
                    acc_next = acc_reg + (part[KEY_W-1:0] << shamt);
                end
                else
                begin
                    acc_next = acc_reg << 4;
                    r_next   = rem[BB-1:0];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    step_reg <= '0;
                end
                else if (start)
                begin
                    busy_reg <= 1'b1;
                    step_reg <= '0;
                end
                else if (busy_reg)
                begin
                    if (step_reg == STEP_W'(LAST_STEP))
                    begin
                        busy_reg <= 1'b0;
                    end
                    step_reg <= step_reg + STEP_W'(1);
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    key_reg <= key_in;
                    acc_reg <= '0;
                    r_reg   <= '0;
                end
                else if (busy_reg)
                begin
                    acc_reg <= acc_next;
                    r_reg   <= r_next;
                end
            end

            assign done   = busy_reg && (step_reg == STEP_W'(LAST_STEP));
            assign bucket = r_next;
        end
    endgenerate

endmodule

// ----- sv/hkvt_match.sv -----
`timescale 1ns / 1ps
// Row update logic: compares the keys of one bucket row and forms the new row.
module hkvt_match
    import hkvt_pkg::*;
#(
    parameter int WAYS  = DEF_WAYS,
    parameter int VAL_W = DEF_VALUE_BITS
)
(
    input  logic [KIND_W-1:0]                 kind,
    input  logic [KEY_W-1:0]                  key,
    input  logic [VAL_W-1:0]                  value,
    input  logic [WAYS-1:0]                   row_valid,
    input  logic [WAYS-1:0][KEY_W-1:0]        row_keys,
    input  logic [WAYS-1:0][VAL_W-1:0]        row_vals,
    output logic [WAYS-1:0]                   new_valid,
    output logic [WAYS-1:0][KEY_W-1:0]        new_keys,
    output logic [WAYS-1:0][VAL_W-1:0]        new_vals,
    output match_res_t                        res
);

    localparam int IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic [WAYS-1:0]  hit;
    logic             hit_any;
    logic [IDX_W-1:0] hit_idx;
    logic             free_any;
    logic [IDX_W-1:0] free_idx;
    logic             arg_bad;

    always_comb
    begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            hit[w] = row_valid[w] && (row_keys[w] == key);
            if (hit[w])
            begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(w);
            end
            if (!row_valid[w])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(w);
            end
        end
    end

    always_comb
    begin
        arg_bad   = (key == '0) ||
                    ((kind inside {KIND_INSERT, KIND_MODIFY}) && (value == '0));
        new_valid = row_valid;
        new_keys  = row_keys;
        new_vals  = row_vals;
        res       = '0;
        res.status = STAT_OK;
        if (arg_bad)
        begin
            res.status = STAT_INVALID;
        end
        else
        begin
            case (kind)
                KIND_INSERT:
                begin
                    if (hit_any)
                    begin
                        res.status = STAT_DUPLICATE;
                    end
                    else if (!free_any)
                    begin
                        res.status = STAT_FULL;
                    end
                    else
                    begin
                        new_valid[free_idx] = 1'b1;
                        new_keys[free_idx]  = key;
                        new_vals[free_idx]  = value;
                        res.wr  = 1'b1;
                        res.inc = 1'b1;
                    end
                end
                KIND_REMOVE:
                begin
                    if (!hit_any)
                    begin
                        res.status = STAT_NOT_FOUND;
                    end
                    else
                    begin
                        new_valid[hit_idx] = 1'b0;
                        res.wr  = 1'b1;
                        res.dec = 1'b1;
                    end
                end
                KIND_MODIFY:
                begin
                    if (!hit_any)
                    begin
                        res.status = STAT_NOT_FOUND;
                    end
                    else
                    begin
                        new_vals[hit_idx] = value;
                        res.wr = 1'b1;
                    end
                end
                KIND_LOOKUP:
                begin
                    if (!hit_any)
                    begin
                        res.status = STAT_NOT_FOUND;
                    end
                    else
                    begin
                        res.value_out = VALUE_W'(row_vals[hit_idx]);
                    end
                end
                default:
                begin
                    res.status = STAT_INVALID;
                end
            endcase
        end
    end

endmodule

// ----- sv/hashed_key_value_table_top.sv -----
`timescale 1ns / 1ps
// Top level of the hashed key-value table: bucket row memory, sequencer and result register.
//
//  channel    handshake             payload
//  request    in_valid / in_ready   kind, key, value_in
//  result     out_valid / out_ready status, value_out, entries
//
// When BUCKETS is a power of two, the row is read at acceptance and written
// back from the compare state. Otherwise the bucket unit first runs its 4
// multiply steps and 16 reduce steps, and the row is read when it is done.
// After reset a clearing pass writes every row once before the first request
// is taken. A stalled result holds the write-back of the next request in its
// compare stage until the result register is free.
module hashed_key_value_table_top
    import hkvt_pkg::*;
#(
    parameter int BUCKETS    = DEF_BUCKETS,
    parameter int WAYS       = DEF_WAYS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [KIND_W-1:0]    kind,
    input  logic [KEY_W-1:0]     key,
    input  logic [VALUE_W-1:0]   value_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATUS_W-1:0]  status,
    output logic [VALUE_W-1:0]   value_out,
    output logic [ENTRIES_W-1:0] entries
);

    localparam int VAL_W  = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int ADDR_W = $clog2(BUCKETS);
    localparam int ROW_W  = WAYS * (1 + KEY_W + VAL_W);
    localparam int CNT_W  = $clog2(BUCKETS * WAYS + 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_HASH  = 2'd2;
    localparam logic [1:0] ST_MATCH = 2'd3;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [ADDR_W-1:0]   clr_idx_reg;
    logic [ADDR_W-1:0]   clr_idx_next;
    logic [ADDR_W-1:0]   addr_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [VALUE_W-1:0]  value_out_reg;
    logic [KIND_W-1:0]   op_kind_reg;
    logic [KEY_W-1:0]    op_key_reg;
    logic [VAL_W-1:0]    op_val_reg;

    logic [ROW_W-1:0]    row_mem [BUCKETS];
    logic [ROW_W-1:0]    rd_data_reg;
    logic [ROW_W-1:0]    wr_data;
    logic [ADDR_W-1:0]   wr_addr;
    logic                mem_rd;
    logic                mem_wr;
    logic                commit;
    logic                accept;

    logic                hash_done;
    logic [ADDR_W-1:0]   hash_bucket;

    logic [WAYS-1:0]             row_valid;
    logic [WAYS-1:0][KEY_W-1:0]  row_keys;
    logic [WAYS-1:0][VAL_W-1:0]  row_vals;
    logic [WAYS-1:0]             new_valid;
    logic [WAYS-1:0][KEY_W-1:0]  new_keys;
    logic [WAYS-1:0][VAL_W-1:0]  new_vals;
    match_res_t                  res;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    hkvt_hash #(
        .BUCKETS (BUCKETS)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .key_in (key),
        .done   (hash_done),
        .bucket (hash_bucket)
    );

    assign row_valid = rd_data_reg[WAYS-1:0];
    assign row_keys  = rd_data_reg[WAYS +: WAYS*KEY_W];
    assign row_vals  = rd_data_reg[WAYS*(1+KEY_W) +: WAYS*VAL_W];

    hkvt_match #(
        .WAYS  (WAYS),
        .VAL_W (VAL_W)
    ) u_match (
        .kind      (op_kind_reg),
        .key       (op_key_reg),
        .value     (op_val_reg),
        .row_valid (row_valid),
        .row_keys  (row_keys),
        .row_vals  (row_vals),
        .new_valid (new_valid),
        .new_keys  (new_keys),
        .new_vals  (new_vals),
        .res       (res)
    );

    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        mem_rd       = 1'b0;
        mem_wr       = 1'b0;
        commit       = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_wr = 1'b1;
                if (clr_idx_reg == ADDR_W'(BUCKETS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + ADDR_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (hash_done)
                    begin
                        mem_rd     = 1'b1;
                        state_next = ST_MATCH;
                    end
                    else
                    begin
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH:
            begin
                if (hash_done)
                begin
                    mem_rd     = 1'b1;
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    commit     = 1'b1;
                    mem_wr     = res.wr;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // During the clearing pass every row is written with all slots empty.
    assign wr_addr = (state_reg == ST_CLEAR) ? clr_idx_reg : addr_reg;
    assign wr_data = (state_reg == ST_CLEAR) ? '0 : {new_vals, new_keys, new_valid};

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            row_mem[wr_addr] <= wr_data;
        end
        if (mem_rd)
        begin
            rd_data_reg <= row_mem[hash_bucket];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
                if (res.inc)
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                else if (res.dec)
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_kind_reg <= kind;
            op_key_reg  <= key;
            op_val_reg  <= value_in[VAL_W-1:0];
        end
        if (mem_rd)
        begin
            addr_reg <= hash_bucket;
        end
        if (commit)
        begin
            status_reg    <= res.status;
            value_out_reg <= res.value_out;
        end
    end

    // The count only moves on a commit, which waits for the result register
    // to be free, so it always matches the result on display.
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value_out = value_out_reg;
    assign entries   = ENTRIES_W'(cnt_reg);

endmodule
